/* rtl/servo_channel_frame_decoder_unit_assert.svh */
// assertion macros for the servo channel frame decoder
`ifndef SERVO_CHANNEL_FRAME_DECODER_UNIT_ASSERT_SVH
`define SERVO_CHANNEL_FRAME_DECODER_UNIT_ASSERT_SVH

// same-cycle implication under reset
`define SCFD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under reset
`define SCFD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/scfd_pkg.sv */
// shared constants for the servo channel frame decoder
`timescale 1ns / 1ps

package scfd_pkg;

    localparam int NUM_CHANNELS_DEF   = 14;
    localparam int BUFFER_DEPTH_DEF   = 32;
    localparam int FRAME_OVERHEAD_DEF = 3;

    // request types
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_BYTE = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_GAP_TICKS   = 2'd0;
    localparam logic [1:0] CFG_MAX_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_COMMAND     = 2'd2;

    localparam logic [7:0] GAP_TICKS_RST  = 8'd3;
    localparam logic [5:0] MAX_LENGTH_RST = 6'd32;
    localparam logic [7:0] COMMAND_RST    = 8'd64;

    localparam logic [15:0] SUM_SEED = 16'hFFFF;

endpackage

/* rtl/scfd_payload_mem.sv */
// payload byte store with per-entry valid bits and registered read
`timescale 1ns / 1ps

module scfd_payload_mem #(
    parameter int DEPTH = scfd_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     rd_zero,
    output logic [7:0]               rd_data
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // entries never written, and positions past the buffer, read as zero
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (rd_zero || !valid_reg[rd_addr])
            begin
                rd_data_reg <= 8'd0;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/servo_channel_frame_decoder_unit.sv */
// servo channel frame decoder top level: parser, commit sequencer, channel table
//
//  channel   direction  handshake           payload
//  in        in         in_valid/in_stall   req_type, rx_byte, channel_index
//  out       out        out_valid/out_stall read_data, frame_accepted,
//                                           checksum_error, length_rejected
//  cfg       in         cfg_we              cfg_index, cfg_data
//
// ticks, reads and most bytes give a registered result; the next request is taken while
// the previous result waits unless that result is still stalled.
// a byte that completes a good command frame stalls the input while the channel bytes
// are read one per cycle through the single read port of the payload store and
// packed into the channel table; its result is given after that.
// reset is asynchronous; the payload store uses valid bits, no clearing pass.
`timescale 1ns / 1ps
`include "servo_channel_frame_decoder_unit_assert.svh"

module servo_channel_frame_decoder_unit #(
    parameter int NUM_CHANNELS   = scfd_pkg::NUM_CHANNELS_DEF,
    parameter int BUFFER_DEPTH   = scfd_pkg::BUFFER_DEPTH_DEF,
    parameter int FRAME_OVERHEAD = scfd_pkg::FRAME_OVERHEAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [7:0]  rx_byte,
    input  logic [7:0]  channel_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] read_data,
    output logic        frame_accepted,
    output logic        checksum_error,
    output logic        length_rejected
);

    localparam int ADDR_W    = $clog2(BUFFER_DEPTH);
    localparam int LEN_W     = $clog2(BUFFER_DEPTH + 1);
    localparam int CNT_W     = $clog2(2 * NUM_CHANNELS + 1);
    localparam int POS_W     = $clog2(2 * NUM_CHANNELS + 2);
    localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int LEN_LIMIT = BUFFER_DEPTH + FRAME_OVERHEAD;

    localparam logic [2:0] PH_DISCARD = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_DATA    = 3'd2;
    localparam logic [2:0] PH_CSUM_LO = 3'd3;
    localparam logic [2:0] PH_CSUM_HI = 3'd4;

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_COMMIT = 1'b1;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(2 * NUM_CHANNELS);

    logic [7:0]  gap_reg;
    logic [5:0]  maxlen_reg;
    logic [7:0]  cmd_reg;

    logic              state_reg, state_next;
    logic [2:0]        phase_reg, phase_next;
    logic [7:0]        idle_reg, idle_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic [15:0]       sum_reg, sum_next;
    logic [7:0]        cklo_reg, cklo_next;
    logic [7:0]        byte0_reg, byte0_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              pend_reg;
    logic [CNT_W-1:0]  pend_idx_reg;
    logic [7:0]        lo_reg;
    logic [15:0]       chan_reg [NUM_CHANNELS];

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg, out_data_next;
    logic        out_acc_reg, out_acc_next;
    logic        out_cks_reg, out_cks_next;
    logic        out_len_reg, out_len_next;

    logic              accept;
    logic              out_take;
    logic [2:0]        ph;
    logic              len_ok;
    logic [LEN_W-1:0]  pos_inc;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [POS_W-1:0]  rd_pos;
    logic              rd_zero;
    logic [7:0]        rd_data;
    logic [CH_W-1:0]   wr_ch;

    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);

    assign len_ok = ({2'b00, rx_byte} <= {4'd0, maxlen_reg}) &&
                    (rx_byte > 8'(FRAME_OVERHEAD)) &&
                    ({1'b0, rx_byte} <= 9'(LEN_LIMIT));
    assign pos_inc = pos_reg + LEN_W'(1);

    assign rd_en   = (state_reg == S_COMMIT) && (cnt_reg < CNT_LAST);
    assign rd_pos  = POS_W'(cnt_reg) + POS_W'(1);
    assign rd_zero = 32'(rd_pos) >= 32'(BUFFER_DEPTH);
    assign wr_ch   = CH_W'(pend_idx_reg >> 1);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        idle_next      = idle_reg;
        pos_next       = pos_reg;
        plen_next      = plen_reg;
        sum_next       = sum_reg;
        cklo_next      = cklo_reg;
        byte0_next     = byte0_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_take;
        out_data_next  = out_data_reg;
        out_acc_next   = out_acc_reg;
        out_cks_next   = out_cks_reg;
        out_len_next   = out_len_reg;
        wr_en          = 1'b0;
        wr_addr        = ADDR_W'(pos_reg);
        ph             = phase_reg;

        if (accept)
        begin
            out_valid_next = 1'b1;
            out_data_next  = 16'd0;
            out_acc_next   = 1'b0;
            out_cks_next   = 1'b0;
            out_len_next   = 1'b0;
            case (req_type)
                scfd_pkg::REQ_TICK:
                begin
                    if (idle_reg != 8'hFF)
                    begin
                        idle_next = idle_reg + 8'd1;
                    end
                end
                scfd_pkg::REQ_BYTE:
                begin
                    // enough silence restarts the frame at its length byte
                    if (idle_reg >= gap_reg)
                    begin
                        ph = PH_LENGTH;
                    end
                    idle_next  = 8'd0;
                    phase_next = ph;
                    case (ph)
                        PH_LENGTH:
                        begin
                            if (len_ok)
                            begin
                                pos_next   = '0;
                                plen_next  = LEN_W'(rx_byte - 8'(FRAME_OVERHEAD));
                                sum_next   = scfd_pkg::SUM_SEED - {8'd0, rx_byte};
                                phase_next = PH_DATA;
                            end
                            else
                            begin
                                out_len_next = 1'b1;
                                phase_next   = PH_DISCARD;
                            end
                        end
                        PH_DATA:
                        begin
                            wr_en    = 1'b1;
                            if (pos_reg == '0)
                            begin
                                byte0_next = rx_byte;
                            end
                            sum_next = sum_reg - {8'd0, rx_byte};
                            pos_next = pos_inc;
                            if (pos_inc >= plen_reg)
                            begin
                                phase_next = PH_CSUM_LO;
                            end
                        end
                        PH_CSUM_LO:
                        begin
                            cklo_next  = rx_byte;
                            phase_next = PH_CSUM_HI;
                        end
                        PH_CSUM_HI:
                        begin
                            phase_next = PH_DISCARD;
                            if (sum_reg == {rx_byte, cklo_reg})
                            begin
                                if (byte0_reg == cmd_reg)
                                begin
                                    // result is given once the channels are in
                                    out_valid_next = 1'b0;
                                    state_next     = S_COMMIT;
                                    cnt_next       = '0;
                                end
                            end
                            else
                            begin
                                out_cks_next = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                scfd_pkg::REQ_READ:
                begin
                    if (32'(channel_index) < 32'(NUM_CHANNELS))
                    begin
                        out_data_next = chan_reg[CH_W'(channel_index)];
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (state_reg == S_COMMIT)
        begin
            if (rd_en)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            else if (!pend_reg)
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
                out_data_next  = 16'd0;
                out_acc_next   = 1'b1;
                out_cks_next   = 1'b0;
                out_len_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg    <= scfd_pkg::GAP_TICKS_RST;
            maxlen_reg <= scfd_pkg::MAX_LENGTH_RST;
            cmd_reg    <= scfd_pkg::COMMAND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                scfd_pkg::CFG_GAP_TICKS:  gap_reg    <= cfg_data;
                scfd_pkg::CFG_MAX_LENGTH: maxlen_reg <= cfg_data[5:0];
                scfd_pkg::CFG_COMMAND:    cmd_reg    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_DISCARD;
            idle_reg      <= 8'd0;
            pos_reg       <= '0;
            plen_reg      <= '0;
            sum_reg       <= 16'd0;
            cklo_reg      <= 8'd0;
            byte0_reg     <= 8'd0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            idle_reg      <= idle_next;
            pos_reg       <= pos_next;
            plen_reg      <= plen_next;
            sum_reg       <= sum_next;
            cklo_reg      <= cklo_next;
            byte0_reg     <= byte0_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_acc_reg  <= out_acc_next;
        out_cks_reg  <= out_cks_next;
        out_len_reg  <= out_len_next;
        pend_idx_reg <= cnt_reg;
        // even counter values (odd payload positions) are low bytes, odd ones complete a channel
        if (pend_reg && !pend_idx_reg[0])
        begin
            lo_reg <= rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                chan_reg[i] <= 16'd0;
            end
        end
        else if (pend_reg && pend_idx_reg[0])
        begin
            chan_reg[wr_ch] <= {rd_data, lo_reg};
        end
    end

    scfd_payload_mem #(
        .DEPTH (BUFFER_DEPTH)
    ) u_payload_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (ADDR_W'(rd_pos)),
        .rd_zero (rd_zero),
        .rd_data (rd_data)
    );

    assign out_valid       = out_valid_reg;
    assign read_data       = out_data_reg;
    assign frame_accepted  = out_acc_reg;
    assign checksum_error  = out_cks_reg;
    assign length_rejected = out_len_reg;

    `SCFD_ASSERT_NOW(a_one_flag, clk, rst_n, out_valid_reg, $onehot0({out_acc_reg, out_cks_reg, out_len_reg}), "more than one status flag in a result")
    `SCFD_ASSERT_NEXT(a_commit_result, clk, rst_n, (state_reg == S_COMMIT) && (state_next == S_IDLE), out_valid_reg && out_acc_reg, "commit ended without an accepted frame result")
    `SCFD_ASSERT_NOW(a_cnt_bound, clk, rst_n, state_reg == S_COMMIT, (cnt_reg <= CNT_LAST) && !out_valid_reg, "commit counter overran or result pending during commit")

endmodule
